// ===== design/mlr_pkg.sv =====
// Shared types and constants for the midpoint line rasterizer.
// Used by mlr_setup, mlr_step and midpoint_line_rasterizer; depends on nothing.
`timescale 1ns / 1ps

package mlr_pkg;

  // Coordinate width of every endpoint and pixel.
  localparam int COORD_BITS = 10;
  // Decision variable width: it stays within (-2*major, 2*minor].
  localparam int DEC_BITS   = COORD_BITS + 2;

  // Request command codes.
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef struct packed {
    logic                  cmd;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
  } mlr_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  pixel_valid;
    logic                  last_pixel;
  } mlr_out_t;

  // Walk state of the line being drawn, folded into the first octant.
  typedef struct packed {
    logic                       active;
    logic                       steep;
    logic                       leftward;
    logic [COORD_BITS-1:0]      origin_x;
    logic [COORD_BITS-1:0]      origin_y;
    logic [COORD_BITS-1:0]      major_len;
    logic [COORD_BITS-1:0]      major_step;
    logic [COORD_BITS-1:0]      minor_step;
    logic signed [DEC_BITS-1:0] decision;
    logic [COORD_BITS:0]        inc_straight;
    logic signed [DEC_BITS-1:0] inc_diagonal;
  } mlr_line_t;

endpackage

// ===== design/mlr_setup.sv =====
// Line setup: orders the endpoints, folds the line into the first octant
// and produces the first pixel. Depends on mlr_pkg.
`timescale 1ns / 1ps

module mlr_setup (
  input  mlr_pkg::mlr_in_t   item,
  output mlr_pkg::mlr_line_t line,
  output mlr_pkg::mlr_out_t  pixel
);
  import mlr_pkg::*;

  logic                  swap;
  logic [COORD_BITS-1:0] xa, ya, xb, yb;
  logic [COORD_BITS-1:0] adx, dy, maj, mnr;
  logic                  leftward, steep;

  always_comb begin
    // Draw every line with y non-decreasing.
    swap = (item.y_end < item.y_start);
    xa   = swap ? item.x_end   : item.x_start;
    ya   = swap ? item.y_end   : item.y_start;
    xb   = swap ? item.x_start : item.x_end;
    yb   = swap ? item.y_start : item.y_end;

    leftward = (xb < xa);
    adx      = leftward ? (xa - xb) : (xb - xa);
    dy       = yb - ya;
    // An exact diagonal is not steep.
    steep    = (dy > adx);
    maj      = steep ? dy  : adx;
    mnr      = steep ? adx : dy;

    line.active       = (maj != '0);
    line.steep        = steep;
    line.leftward     = leftward;
    line.origin_x     = xa;
    line.origin_y     = ya;
    line.major_len    = maj;
    line.major_step   = '0;
    line.minor_step   = '0;
    line.decision     = $signed({1'b0, mnr, 1'b0} - {2'b00, maj});
    line.inc_straight = {mnr, 1'b0};
    line.inc_diagonal = $signed({1'b0, mnr, 1'b0} - {1'b0, maj, 1'b0});

    pixel.pixel_x     = xa;
    pixel.pixel_y     = ya;
    pixel.pixel_valid = 1'b1;
    pixel.last_pixel  = (maj == '0);
  end

endmodule

// ===== design/mlr_step.sv =====
// One midpoint step: updates the decision variable and emits the next pixel.
// Depends on mlr_pkg.
`timescale 1ns / 1ps

module mlr_step (
  input  mlr_pkg::mlr_line_t line,
  output mlr_pkg::mlr_line_t line_nxt,
  output mlr_pkg::mlr_out_t  pixel
);
  import mlr_pkg::*;

  logic                  go_straight;
  logic [COORD_BITS-1:0] major_nxt, minor_nxt, along_x, along_y;
  logic                  last;

  always_comb begin
    // Ties take the straight step.
    go_straight = line.decision[DEC_BITS-1] || (line.decision == '0);
    major_nxt   = line.major_step + 1'b1;
    minor_nxt   = go_straight ? line.minor_step : (line.minor_step + 1'b1);
    along_x     = line.steep ? minor_nxt : major_nxt;
    along_y     = line.steep ? major_nxt : minor_nxt;
    last        = (major_nxt >= line.major_len);

    line_nxt = line;
    pixel    = '0;
    if (line.active) begin
      line_nxt.decision   = go_straight ?
                            (line.decision + $signed({1'b0, line.inc_straight})) :
                            (line.decision + line.inc_diagonal);
      line_nxt.major_step = major_nxt;
      line_nxt.minor_step = minor_nxt;
      line_nxt.active     = !last;
      pixel.pixel_x       = line.leftward ? (line.origin_x - along_x) :
                                            (line.origin_x + along_x);
      pixel.pixel_y       = line.origin_y + along_y;
      pixel.pixel_valid   = 1'b1;
      pixel.last_pixel    = last;
    end
  end

endmodule

// ===== design/midpoint_line_rasterizer.sv =====
// Flow: an accepted request waits in the input register; its result is presented
//   from the result register. Throughput: one request, one pixel per cycle while
//   out_ready is high; the combinational walk update between the registers sets it.
// Reset: rst_n is synchronous and active low; it empties both registers and
//   drops any active line. An advance before the first start gives an invalid pixel.
`timescale 1ns / 1ps

module midpoint_line_rasterizer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mlr_pkg::mlr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mlr_pkg::mlr_out_t out_data
);
  import mlr_pkg::*;

  // Input register: holds one accepted request until its result is computed.
  logic      in_vld_r;
  mlr_in_t   in_item_r;
  // Walk state of the current line.
  mlr_line_t line_r, line_nxt;
  // Result register.
  logic      out_vld_r;
  mlr_out_t  out_r;

  mlr_line_t setup_line, step_line;
  mlr_out_t  setup_pixel, step_pixel, pixel_nxt;
  logic      move;

  // The request in the input register is processed in the cycle its result
  // can be written, which is whenever the result register is empty or being
  // drained. The walk state advances in that same cycle, so each request
  // sees the state left by the one before it.
  assign move     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || move;

  mlr_setup u_setup (
    .item  (in_item_r),
    .line  (setup_line),
    .pixel (setup_pixel)
  );

  mlr_step u_step (
    .line     (line_r),
    .line_nxt (step_line),
    .pixel    (step_pixel)
  );

  // A start replaces any line still in progress.
  always_comb begin
    if (in_item_r.cmd == CMD_START) begin
      line_nxt  = setup_line;
      pixel_nxt = setup_pixel;
    end else begin
      line_nxt  = step_line;
      pixel_nxt = step_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      line_r.active <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (move) begin
        out_vld_r <= 1'b1;
        line_r    <= line_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
    if (move) begin
      out_r <= pixel_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  // An active line never has walked past its length.
  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    line_r.active |-> (line_r.major_step < line_r.major_len))
    else $error("active line has no steps left");

  // The minor axis never moves more often than the major axis.
  a_minor_le_major: assert property (@(posedge clk) disable iff (!rst_n)
    line_r.active |-> (line_r.minor_step <= line_r.major_step))
    else $error("minor step count exceeds major step count");

  // Emitting the final pixel ends the line.
  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (move && pixel_nxt.last_pixel) |=> !line_r.active)
    else $error("line still active after its last pixel");

  // An advance with no line gives an all-zero result.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_r.pixel_valid) |->
      ((out_r.pixel_x == '0) && (out_r.pixel_y == '0) && !out_r.last_pixel))
    else $error("result without a pixel carries data");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for midpoint_line_rasterizer: directed lines, then random lines.
// Each request is predicted when it is accepted and checked pixel by pixel; needs mlr_pkg.
`timescale 1ns / 1ps

module tb_top;
  import mlr_pkg::*;

  // Run length: the directed tests send 24 requests, and the random lines
  // bring the total to about this many.
  localparam int TOTAL_REQUESTS = 1775;
  localparam int COORD_MAX      = (1 << COORD_BITS) - 1;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  mlr_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  mlr_out_t out_data;

  midpoint_line_rasterizer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Walk state of the line being traced, folded into the first octant.
  // Coordinates and steps are 10 bits, as in the block; the 13-bit signed
  // decision value and its two increments are wider here than in the block.
  typedef struct {
    bit                    active;
    bit                    steep;
    bit                    leftward;
    logic [COORD_BITS-1:0] origin_x;
    logic [COORD_BITS-1:0] origin_y;
    logic [COORD_BITS-1:0] major_len;
    logic [COORD_BITS-1:0] major_step;
    logic [COORD_BITS-1:0] minor_step;
    logic signed [12:0]    decision;
    logic [11:0]           inc_straight;
    logic signed [12:0]    inc_diagonal;
  } line_walk_t;

  line_walk_t walk = '{default: 0};
  mlr_out_t   pixel_expected[$];
  int         requests_sent = 0;
  int         error_count   = 0;
  bit         steady_sender = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the handshake hangs; the slowest legal run is far shorter.
  initial begin
    #10_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // Works out the pixel that one request should produce and moves the walk
  // state on. A start swaps the endpoints when the end lies below the start,
  // so y never decreases along the line, then folds the line into the first
  // octant. The steep decision is taken from the deltas before any axis swap.
  function automatic mlr_out_t trace_next_pixel(mlr_in_t req);
    mlr_out_t              pix;
    int                    xa, ya, xb, yb, swap_tmp;
    int                    dx, dy, adx, maj, mnr;
    logic [COORD_BITS-1:0] along_x, along_y;
    pix = '0;
    if (req.cmd == CMD_START) begin
      xa = req.x_start;
      ya = req.y_start;
      xb = req.x_end;
      yb = req.y_end;
      if (yb < ya) begin
        swap_tmp = xa; xa = xb; xb = swap_tmp;
        swap_tmp = ya; ya = yb; yb = swap_tmp;
      end
      dx = xb - xa;
      dy = yb - ya;
      walk.leftward = dx < 0;
      adx = walk.leftward ? -dx : dx;
      // An exact diagonal is not steep.
      walk.steep = dy > adx;
      maj = walk.steep ? dy : adx;
      mnr = walk.steep ? adx : dy;
      walk.origin_x     = xa[COORD_BITS-1:0];
      walk.origin_y     = ya[COORD_BITS-1:0];
      walk.major_len    = maj[COORD_BITS-1:0];
      walk.major_step   = '0;
      walk.minor_step   = '0;
      walk.decision     = 13'(2 * mnr - maj);
      walk.inc_straight = 12'(2 * mnr);
      walk.inc_diagonal = 13'(2 * (mnr - maj));
      // A single-point line is finished as soon as it starts.
      walk.active       = maj > 0;
      pix.pixel_x     = walk.origin_x;
      pix.pixel_y     = walk.origin_y;
      pix.pixel_valid = 1'b1;
      pix.last_pixel  = (maj == 0);
      return pix;
    end
    // Advancing with no line in progress yields an all-zero, invalid pixel.
    if (!walk.active) return pix;
    // A tie on the decision value takes the straight step.
    if (walk.decision <= 0) begin
      walk.decision = walk.decision + $signed({1'b0, walk.inc_straight});
    end else begin
      walk.decision = walk.decision + walk.inc_diagonal;
      walk.minor_step = walk.minor_step + 1'b1;
    end
    walk.major_step = walk.major_step + 1'b1;
    along_x = walk.steep ? walk.minor_step : walk.major_step;
    along_y = walk.steep ? walk.major_step : walk.minor_step;
    pix.pixel_x     = walk.leftward ? walk.origin_x - along_x : walk.origin_x + along_x;
    pix.pixel_y     = walk.origin_y + along_y;
    pix.pixel_valid = 1'b1;
    pix.last_pixel  = walk.major_step >= walk.major_len;
    if (pix.last_pixel) walk.active = 1'b0;
    return pix;
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_idle();
    int roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Presents one request and holds it until accepted. The prediction is made
  // at the accepting edge. Valid is only lowered when a gap follows, so that
  // back-to-back requests keep it high without a glitch.
  task automatic send_request(input logic cmd, input int xs, input int ys,
                              input int xe, input int ye);
    mlr_in_t req;
    int      gap;
    req.cmd     = cmd;
    req.x_start = xs[COORD_BITS-1:0];
    req.y_start = ys[COORD_BITS-1:0];
    req.x_end   = xe[COORD_BITS-1:0];
    req.y_end   = ye[COORD_BITS-1:0];
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pixel_expected.push_back(trace_next_pixel(req));
    requests_sent++;
    gap = steady_sender ? 0 : pick_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Advance requests carry random coordinates, which the block must ignore.
  task automatic advance_line(input int count);
    repeat (count) send_request(CMD_ADVANCE, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Stops sending and waits until every predicted pixel has been checked.
  task automatic wait_for_pixels();
    in_valid <= 1'b0;
    do @(posedge clk); while (pixel_expected.size() != 0);
  endtask

  // Result side: every accepted pixel is matched against the oldest prediction.
  always @(posedge clk) begin : check_pixels
    mlr_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pixel_expected.size() == 0) begin
        $error("unexpected pixel x=%0d y=%0d valid=%0b last=%0b", out_data.pixel_x,
               out_data.pixel_y, out_data.pixel_valid, out_data.last_pixel);
        error_count++;
      end else begin
        want = pixel_expected.pop_front();
        if (out_data.pixel_x !== want.pixel_x) begin
          $error("pixel_x expected %0d got %0d", want.pixel_x, out_data.pixel_x);
          error_count++;
        end
        if (out_data.pixel_y !== want.pixel_y) begin
          $error("pixel_y expected %0d got %0d", want.pixel_y, out_data.pixel_y);
          error_count++;
        end
        if (out_data.pixel_valid !== want.pixel_valid) begin
          $error("pixel_valid expected %0b got %0b", want.pixel_valid,
                 out_data.pixel_valid);
          error_count++;
        end
        if (out_data.last_pixel !== want.last_pixel) begin
          $error("last_pixel expected %0b got %0b", want.last_pixel,
                 out_data.last_pixel);
          error_count++;
        end
      end
    end
  end

  // Receiver back-pressure: bursts of ready broken by stalls, with an
  // occasional long burst so that some stretches see no stall at all.
  initial begin : drive_out_ready
    int run_len;
    int stall_len;
    @(posedge clk iff rst_n);
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                            : $urandom_range(1, 30);
      repeat (run_len) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
      stall_len = pick_idle();
      repeat (stall_len) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Advancing before any line was started must give an invalid pixel.
  task automatic test_no_line();
    advance_line(1);
  endtask

  // A line whose endpoints coincide ends at its first pixel; the advance
  // after it finds no line left.
  task automatic test_single_point();
    send_request(CMD_START, COORD_MAX, 0, COORD_MAX, 0);
    advance_line(1);
  endtask

  // A vertical line drawn downward gets its endpoints swapped, so it is
  // walked upward from the lower endpoint.
  task automatic test_vertical_down();
    send_request(CMD_START, 7, 9, 7, 6);
    advance_line(3);
  endtask

  // An exact diagonal toward smaller x: mirrored, and walked as shallow.
  task automatic test_diagonal();
    send_request(CMD_START, 4, 1, 1, 4);
    advance_line(3);
  endtask

  // A 4-by-2 line starts with a decision value of zero, so the first step
  // must be the straight one.
  task automatic test_midpoint_tie();
    send_request(CMD_START, 0, 0, 4, 2);
    advance_line(4);
  endtask

  // Endpoints at the corners of the coordinate range. Each new start drops
  // the line still in progress. The sender also holds off once until the
  // block has delivered every pixel.
  task automatic test_extremes();
    send_request(CMD_START, 0, 0, COORD_MAX, COORD_MAX);
    advance_line(2);
    wait_for_pixels();
    send_request(CMD_START, COORD_MAX, COORD_MAX, 0, 0);
    advance_line(2);
    send_request(CMD_START, COORD_MAX, 0, 0, COORD_MAX);
    advance_line(1);
  endtask

  // Random lines: mostly short ones walked to their end (sometimes one step
  // further), some cut short by the next start, a few spanning the whole
  // range, plus random requests of either kind as noise.
  task automatic test_random_lines();
    int pick, walk_pick;
    int x0, y0, x1, y1;
    int len_x, len_y, len, steps;
    while (requests_sent < TOTAL_REQUESTS) begin
      pick = $urandom_range(0, 99);
      steady_sender = ($urandom_range(0, 3) == 0);
      if (pick < 4) wait_for_pixels();
      if (pick < 10) begin
        send_request(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom);
      end else begin
        x0 = $urandom_range(0, COORD_MAX);
        y0 = $urandom_range(0, COORD_MAX);
        if (pick < 14) begin
          x1 = $urandom_range(0, COORD_MAX);
          y1 = $urandom_range(0, COORD_MAX);
        end else begin
          x1 = $urandom_range(x0 > 16 ? x0 - 16 : 0, x0 < COORD_MAX - 16 ? x0 + 16 : COORD_MAX);
          y1 = $urandom_range(y0 > 16 ? y0 - 16 : 0, y0 < COORD_MAX - 16 ? y0 + 16 : COORD_MAX);
        end
        len_x = (x1 > x0) ? x1 - x0 : x0 - x1;
        len_y = (y1 > y0) ? y1 - y0 : y0 - y1;
        len   = (len_x > len_y) ? len_x : len_y;
        walk_pick = $urandom_range(0, 9);
        if (pick == 10) begin
          // A rare full-length walk of a long line.
          steps = len + 1;
        end else if (pick < 14) begin
          steps = $urandom_range(0, 24);
        end else if (walk_pick < 6) begin
          steps = len;
        end else if (walk_pick < 8) begin
          steps = len + 1;
        end else begin
          steps = $urandom_range(0, len);
        end
        send_request(CMD_START, x0, y0, x1, y1);
        advance_line(steps);
      end
    end
    steady_sender = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_no_line();
    test_single_point();
    test_vertical_down();
    test_diagonal();
    test_midpoint_tie();
    test_extremes();
    test_random_lines();
    wait_for_pixels();
    // The extra wait catches any stray pixel.
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
